### src/sliding_window_load_meter_top_defines.svh
// assertion macros for the sliding window load meter checker
`ifndef SLIDING_WINDOW_LOAD_METER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_LOAD_METER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SWLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SWLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/swlm_pkg.sv
// shared types, widths and codes of the sliding window load meter
package swlm_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int DUR_W      = 32;
  localparam int STAMP_W    = 64;
  localparam int OP_W       = 2;
  localparam int PCT_W      = 7;
  localparam int REC_W      = 7;
  localparam int WIN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = DUR_W + CNT_W;
  localparam int ALU_W      = SUM_W + PCT_W;
  localparam int DIVK_W     = $clog2(PCT_W);

  localparam logic [OP_W-1:0] OP_SLEEP = 2'd0;
  localparam logic [OP_W-1:0] OP_WAKE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW  = 2'd1;

  localparam logic [REC_W-1:0] MAX_RECORDS_RST = 7'd64;
  localparam logic [WIN_W-1:0] MAX_WINDOW_RST  = 32'd1000000;
  localparam logic [PCT_W-1:0] PCT_SCALE       = 7'd100;

  typedef struct packed {
    logic             sleep;
    logic [DUR_W-1:0] dur;
  } ring_entry_t;

  typedef struct packed {
    logic               wr_en;
    logic [RING_AW-1:0] wr_addr;
    ring_entry_t        wr_data;
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
  } ring_req_t;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             borrow;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_REC,
    ST_SUM,
    ST_TOT,
    ST_DCHK,
    ST_DTOT,
    ST_DRUN,
    ST_MUL,
    ST_DIV
  } state_t;

endpackage

### src/sliding_window_load_meter_top.sv
// sliding window load meter: sequencer, state registers and unit hookup
//
// Input beat: start with in_operation and in_now_usec, taken when busy is low.
// Operations: sleep event (closes a run interval), wake event (closes a sleep
// interval), load query. Operation code 3 is taken and ignored.
// Events give no result. A query gives one beat on out_load_percent, marked
// by a one-cycle out_valid strobe. The query reads every held record, then
// drops oldest records while the window or record limit is exceeded, then
// multiplies and divides; a windowed total of zero gives 0 without division.
// Its duration is set by the single ring read port (one record a cycle), the
// shared adder used for both sums and drops, and seven restoring division steps.
// busy stays high from the taken beat until the result strobe; the next beat
// may be taken in the strobe cycle. The receiver cannot stall: each result
// is shown for one cycle only.
// Configuration beats (cfg_valid, cfg_ready always high) write max_records
// at index 0 and max_window_usec at index 1, and should arrive while idle.
// Reset: ring empty, sleeping, both stamps zero, limits 64 and 1000000.
module sliding_window_load_meter_top import swlm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [STAMP_W-1:0]    in_now_usec,
  output logic                  out_valid,
  output logic [PCT_W-1:0]      out_load_percent,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [RING_AW:0] DEPTH_P   = (RING_AW + 1)'(RING_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

  function automatic logic [RING_AW-1:0] ring_wrap(input logic [RING_AW:0] p);
    logic [RING_AW:0] q;
    begin
      q = (p >= DEPTH_P) ? p - DEPTH_P : p;
      return q[RING_AW-1:0];
    end
  endfunction

  state_t               state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [STAMP_W-1:0]   now_r, now_nxt;
  logic [DUR_W-1:0]     dur_r, dur_nxt;
  logic [RING_AW-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 sleeping_r, sleeping_nxt;
  logic [STAMP_W-1:0]   sleep_stamp_r, sleep_stamp_nxt;
  logic [STAMP_W-1:0]   wake_stamp_r, wake_stamp_nxt;
  logic [REC_W-1:0]     max_rec_r, max_rec_nxt;
  logic [WIN_W-1:0]     max_win_r, max_win_nxt;
  logic [SUM_W-1:0]     run_r, run_nxt;
  logic [SUM_W-1:0]     slp_r, slp_nxt;
  logic [SUM_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [ALU_W-1:0]     rem_r, rem_nxt;
  logic [PCT_W-1:0]     quo_r, quo_nxt;
  logic [DIVK_W-1:0]    div_k_r, div_k_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0]     out_load_r, out_load_nxt;

  ring_req_t            ring_req;
  ring_entry_t          rd_data;
  alu_op_t              alu_op;
  logic [ALU_W-1:0]     alu_a, alu_b;
  alu_res_t             alu_res;

  logic [CNT_W-1:0]     lim;
  logic [STAMP_W-1:0]   stamp_sel;
  logic [STAMP_W:0]     sdiff;
  logic [DUR_W-1:0]     span_dur;
  logic [RING_AW-1:0]   head_inc;
  logic [RING_AW-1:0]   rec_addr;
  logic                 ring_full;
  logic                 cnt_over;
  logic [PCT_W-1:0]     quo_set;

  swlm_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (rd_data)
  );

  swlm_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // record limit clamps to the ring depth
  always_comb begin
    if (int'(max_rec_r) > RING_DEPTH) begin
      lim = DEPTH_CNT;
    end else begin
      lim = CNT_W'(max_rec_r);
    end
  end

  always_comb begin
    case (op_r)
      OP_SLEEP: stamp_sel = wake_stamp_r;
      OP_WAKE:  stamp_sel = sleep_stamp_r;
      default:  stamp_sel = sleeping_r ? sleep_stamp_r : wake_stamp_r;
    endcase
  end

  // backwards time gives zero, long spans saturate
  assign sdiff    = {1'b0, now_r} - {1'b0, stamp_sel};
  assign span_dur = sdiff[STAMP_W] ? '0 :
                    (|sdiff[STAMP_W-1:DUR_W]) ? '1 : sdiff[DUR_W-1:0];

  assign head_inc  = ring_wrap({1'b0, head_r} + (RING_AW + 1)'(1));
  assign ring_full = (count_r == DEPTH_CNT);
  assign rec_addr  = ring_full ? head_r :
                     ring_wrap({1'b0, head_r} + (RING_AW + 1)'(count_r));
  assign cnt_over  = ((CNT_W + 1)'(count_r) + (CNT_W + 1)'(1)) > (CNT_W + 1)'(lim);
  assign quo_set   = quo_r | (PCT_W'(1) << div_k_r);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    now_nxt         = now_r;
    dur_nxt         = dur_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    sleeping_nxt    = sleeping_r;
    sleep_stamp_nxt = sleep_stamp_r;
    wake_stamp_nxt  = wake_stamp_r;
    max_rec_nxt     = max_rec_r;
    max_win_nxt     = max_win_r;
    run_nxt         = run_r;
    slp_nxt         = slp_r;
    total_nxt       = total_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    div_k_nxt       = div_k_r;
    out_valid_nxt   = 1'b0;
    out_load_nxt    = out_load_r;
    ring_req        = '0;
    alu_op          = ALU_ADD;
    alu_a           = '0;
    alu_b           = '0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RECORDS: max_rec_nxt = cfg_data[REC_W-1:0];
        CFG_MAX_WINDOW:  max_win_nxt = cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          now_nxt   = in_now_usec;
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        dur_nxt = span_dur;
        case (op_r)
          OP_SLEEP, OP_WAKE: state_nxt = ST_REC;
          OP_QUERY: begin
            // open interval seeds the matching sum
            run_nxt   = sleeping_r ? '0 : SUM_W'(span_dur);
            slp_nxt   = sleeping_r ? SUM_W'(span_dur) : '0;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_SUM;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_REC: begin
        ring_req.wr_en         = 1'b1;
        ring_req.wr_addr       = rec_addr;
        ring_req.wr_data.sleep = (op_r == OP_WAKE);
        ring_req.wr_data.dur   = dur_r;
        // a full ring overwrites the oldest, otherwise one drop past the limit
        if (ring_full || cnt_over) begin
          head_nxt = head_inc;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
        if (op_r == OP_SLEEP) begin
          sleeping_nxt    = 1'b1;
          sleep_stamp_nxt = now_r;
        end else begin
          sleeping_nxt   = 1'b0;
          wake_stamp_nxt = now_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        // read issued last cycle lands now
        if (pend_r) begin
          alu_op = ALU_ADD;
          alu_a  = ALU_W'(rd_data.sleep ? slp_r : run_r);
          alu_b  = ALU_W'(rd_data.dur);
          if (rd_data.sleep) begin
            slp_nxt = alu_res.value[SUM_W-1:0];
          end else begin
            run_nxt = alu_res.value[SUM_W-1:0];
          end
        end
        if (idx_r < count_r) begin
          ring_req.rd_en   = 1'b1;
          ring_req.rd_addr = ring_wrap({1'b0, head_r} + (RING_AW + 1)'(idx_r));
          idx_nxt          = idx_r + CNT_W'(1);
          pend_nxt         = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_TOT;
          end
        end
      end
      ST_TOT: begin
        alu_op    = ALU_ADD;
        alu_a     = ALU_W'(run_r);
        alu_b     = ALU_W'(slp_r);
        total_nxt = alu_res.value[SUM_W-1:0];
        state_nxt = ST_DCHK;
      end
      ST_DCHK: begin
        // oldest record is fetched ahead of the decision
        ring_req.rd_en   = 1'b1;
        ring_req.rd_addr = head_r;
        if (count_r != '0 && (total_r > SUM_W'(max_win_r) || count_r > lim)) begin
          state_nxt = ST_DTOT;
        end else if (total_r == '0) begin
          out_valid_nxt = 1'b1;
          out_load_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DTOT: begin
        alu_op    = ALU_SUB;
        alu_a     = ALU_W'(total_r);
        alu_b     = ALU_W'(rd_data.dur);
        total_nxt = alu_res.value[SUM_W-1:0];
        state_nxt = ST_DRUN;
      end
      ST_DRUN: begin
        if (!rd_data.sleep) begin
          alu_op  = ALU_SUB;
          alu_a   = ALU_W'(run_r);
          alu_b   = ALU_W'(rd_data.dur);
          run_nxt = alu_res.value[SUM_W-1:0];
        end
        head_nxt  = head_inc;
        count_nxt = count_r - CNT_W'(1);
        state_nxt = ST_DCHK;
      end
      ST_MUL: begin
        rem_nxt   = ALU_W'(run_r) * ALU_W'(PCT_SCALE);
        quo_nxt   = '0;
        div_k_nxt = DIVK_W'(PCT_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: quotient never reaches 128 since run <= total
        alu_op = ALU_SUB;
        alu_a  = rem_r;
        alu_b  = ALU_W'(total_r) << div_k_r;
        if (!alu_res.borrow) begin
          rem_nxt = alu_res.value;
          quo_nxt = quo_set;
        end
        if (div_k_r == '0) begin
          out_valid_nxt = 1'b1;
          out_load_nxt  = alu_res.borrow ? quo_r : quo_set;
          state_nxt     = ST_IDLE;
        end else begin
          div_k_nxt = div_k_r - DIVK_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      sleeping_r    <= 1'b1;
      sleep_stamp_r <= '0;
      wake_stamp_r  <= '0;
      max_rec_r     <= MAX_RECORDS_RST;
      max_win_r     <= MAX_WINDOW_RST;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      sleeping_r    <= sleeping_nxt;
      sleep_stamp_r <= sleep_stamp_nxt;
      wake_stamp_r  <= wake_stamp_nxt;
      max_rec_r     <= max_rec_nxt;
      max_win_r     <= max_win_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    dur_r      <= dur_nxt;
    run_r      <= run_nxt;
    slp_r      <= slp_nxt;
    total_r    <= total_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_k_r    <= div_k_nxt;
    out_load_r <= out_load_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_load_percent = out_load_r;

endmodule

### src/swlm_ring.sv
// interval record memory: one write port, one registered read port
module swlm_ring import swlm_pkg::*; (
  input  logic        clk,
  input  ring_req_t   req,
  output ring_entry_t rd_data
);

  ring_entry_t mem [RING_DEPTH];
  ring_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/swlm_alu.sv
// shared add/subtract unit with borrow out, used for sums, drops and division
module swlm_alu import swlm_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output alu_res_t         res
);

  logic [ALU_W:0] full;

  always_comb begin
    case (op)
      ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default: full = {1'b0, a} + {1'b0, b};
    endcase
  end

  assign res.value  = full[ALU_W-1:0];
  assign res.borrow = full[ALU_W];

endmodule

### src/swlm_checker.sv
// port-level checks of the sliding window load meter, bound to the top level
`include "sliding_window_load_meter_top_defines.svh"

module swlm_checker import swlm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [OP_W-1:0]  in_operation,
  input logic             out_valid,
  input logic [PCT_W-1:0] out_load_percent
);

  `SWLM_ASSERT_NOW(a_result_when_idle, clk, rst_n, out_valid, !busy, "result beat while busy")
  `SWLM_ASSERT_NEXT(a_result_one_cycle, clk, rst_n, out_valid, !out_valid, "result strobe too long")
  `SWLM_ASSERT_NOW(a_result_range, clk, rst_n, out_valid, out_load_percent <= PCT_SCALE, "load above 100")
  `SWLM_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && in_operation == OP_QUERY, busy, "query not taken")

endmodule

bind sliding_window_load_meter_top swlm_checker u_swlm_checker (.*);
